// File: design/cpab_pkg.sv
// Shared types and constants for the clipped pixel alpha blend block.
`default_nettype none

package cpab_pkg;

  localparam int CoordBits = 16;
  localparam int LenBits   = CoordBits - 1;
  localparam int SumBits   = CoordBits + 1;
  localparam int PosBits   = 13;
  localparam int FbBits    = 14;
  localparam int CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FB_WIDTH    = 3'd0,
    REG_FB_HEIGHT   = 3'd1,
    REG_CLIP_LEFT   = 3'd2,
    REG_CLIP_TOP    = 3'd3,
    REG_CLIP_WIDTH  = 3'd4,
    REG_CLIP_HEIGHT = 3'd5,
    REG_DRAW_COLOR  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    ACT_RECT_FILL = 1'b0,
    ACT_GLYPH     = 1'b1
  } action_t;

  typedef struct packed {
    logic [FbBits-1:0]           fb_width;
    logic [FbBits-1:0]           fb_height;
    logic signed [CoordBits-1:0] clip_left;
    logic signed [CoordBits-1:0] clip_top;
    logic [LenBits-1:0]          clip_width;
    logic [LenBits-1:0]          clip_height;
    logic [31:0]                 draw_color;
  } cfg_t;

  typedef struct packed {
    logic                        action;
    logic [PosBits-1:0]          pixel_x;
    logic [PosBits-1:0]          pixel_y;
    logic [31:0]                 dest_pixel;
    logic [7:0]                  coverage;
    logic signed [CoordBits-1:0] box_left;
    logic signed [CoordBits-1:0] box_top;
    logic [LenBits-1:0]          box_width;
    logic [LenBits-1:0]          box_height;
  } in_t;

  typedef struct packed {
    logic [31:0] new_pixel;
    logic        write_enable;
  } out_t;

endpackage

`default_nettype wire

// File: design/cpab_clip.sv
// Inside test of one axis against box, clip window and framebuffer.
`default_nettype none

module cpab_clip import cpab_pkg::*; (
  input  wire logic [PosBits-1:0]          pos,
  input  wire logic signed [CoordBits-1:0] box_lo,
  input  wire logic [LenBits-1:0]          box_len,
  input  wire logic signed [CoordBits-1:0] clip_lo,
  input  wire logic [LenBits-1:0]          clip_len,
  input  wire logic [FbBits-1:0]           fb_len,
  output logic                             in_range
);

  logic signed [SumBits-1:0] pos_s;
  logic signed [SumBits-1:0] box_lo_s;
  logic signed [SumBits-1:0] clip_lo_s;
  logic signed [SumBits-1:0] box_hi_s;
  logic signed [SumBits-1:0] clip_hi_s;
  logic                      in_box;
  logic                      in_clip;
  logic                      in_fb;

  // Position is never negative, so the lower framebuffer bound always holds.
  always_comb begin
    pos_s     = $signed(SumBits'(pos));
    box_lo_s  = SumBits'(box_lo);
    clip_lo_s = SumBits'(clip_lo);
    box_hi_s  = box_lo_s + $signed(SumBits'(box_len));
    clip_hi_s = clip_lo_s + $signed(SumBits'(clip_len));
    in_box    = (pos_s >= box_lo_s) && (pos_s < box_hi_s);
    in_clip   = (pos_s >= clip_lo_s) && (pos_s < clip_hi_s);
    in_fb     = FbBits'(pos) < fb_len;
    in_range  = in_box && in_clip && in_fb;
  end

endmodule

`default_nettype wire

// File: design/cpab_blend.sv
// Source-over blend of red, green and blue with opaque fill bypass; dest passes through unchanged when not writing.
`default_nettype none

module cpab_blend import cpab_pkg::*; (
  input  wire logic        action,
  input  wire logic [31:0] dest,
  input  wire logic [7:0]  coverage,
  input  wire logic [31:0] color,
  input  wire logic        write_en,
  output logic [31:0]      new_pixel
);

  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic        opaque;
  logic [16:0] acc;
  logic [16:0] quo;
  logic [31:0] blended;

  // floor(x/255) for x up to 255*255: (x + (x >> 8) + 1) >> 8
  always_comb begin
    alpha     = (action == ACT_GLYPH) ? coverage : color[31:24];
    inv_alpha = 8'hff - alpha;
    opaque    = (action == ACT_RECT_FILL) && (color[31:24] == 8'hff);
    blended   = 32'hff00_0000;
    acc       = '0;
    quo       = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 17'(16'(dest[ch*8 +: 8] * inv_alpha)) + 17'(16'(color[ch*8 +: 8] * alpha));
      quo = (acc + 17'(acc[16:8]) + 17'd1) >> 8;
      blended[ch*8 +: 8] = quo[7:0];
    end
    if (!write_en) begin
      new_pixel = dest;
    end else if (opaque) begin
      new_pixel = color;
    end else begin
      new_pixel = blended;
    end
  end

endmodule

`default_nettype wire

// File: design/clipped_pixel_alpha_blend.sv
// Top level of the clipped pixel alpha blend block.
//
// Input beats (in_valid/in_ready/in_data) carry one destination pixel, its
// coordinates, the box being drawn and the action. Each beat yields exactly
// one output beat (out_valid/out_ready/out_data) holding the pixel to write
// and write_enable, set when the pixel lies inside the box clipped to the
// clip window and the framebuffer.
// Configuration writes arrive on cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Indices outside the register list are ignored.
// A beat passes an input register, then the clip test and blend, then the
// output register. Throughput is one beat per cycle while out_ready holds;
// the blend is two 8x8 multiplies and a divide-by-255 correction per channel.
// When the receiver stalls, the output register holds its beat and the input
// register keeps accepting until it too is full, then in_ready drops.
// Synchronous reset empties both stages and clears the configuration
// registers to zero.
`default_nettype none

module clipped_pixel_alpha_blend import cpab_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [31:0]           cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic s1_valid_r;
  in_t  s1_data_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t res_nxt;
  logic s1_ready;
  logic inside_x;
  logic inside_y;
  logic write_en;
  logic [31:0] blend_pixel;

  assign cfg_ready = 1'b1;
  assign s1_ready  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FB_WIDTH:    cfg_nxt.fb_width    = cfg_data[FbBits-1:0];
        REG_FB_HEIGHT:   cfg_nxt.fb_height   = cfg_data[FbBits-1:0];
        REG_CLIP_LEFT:   cfg_nxt.clip_left   = cfg_data[CoordBits-1:0];
        REG_CLIP_TOP:    cfg_nxt.clip_top    = cfg_data[CoordBits-1:0];
        REG_CLIP_WIDTH:  cfg_nxt.clip_width  = cfg_data[LenBits-1:0];
        REG_CLIP_HEIGHT: cfg_nxt.clip_height = cfg_data[LenBits-1:0];
        REG_DRAW_COLOR:  cfg_nxt.draw_color  = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  cpab_clip u_clip_x (
    .pos      (s1_data_r.pixel_x),
    .box_lo   (s1_data_r.box_left),
    .box_len  (s1_data_r.box_width),
    .clip_lo  (cfg_r.clip_left),
    .clip_len (cfg_r.clip_width),
    .fb_len   (cfg_r.fb_width),
    .in_range (inside_x)
  );

  cpab_clip u_clip_y (
    .pos      (s1_data_r.pixel_y),
    .box_lo   (s1_data_r.box_top),
    .box_len  (s1_data_r.box_height),
    .clip_lo  (cfg_r.clip_top),
    .clip_len (cfg_r.clip_height),
    .fb_len   (cfg_r.fb_height),
    .in_range (inside_y)
  );

  assign write_en = inside_x && inside_y;

  cpab_blend u_blend (
    .action    (s1_data_r.action),
    .dest      (s1_data_r.dest_pixel),
    .coverage  (s1_data_r.coverage),
    .color     (cfg_r.draw_color),
    .write_en  (write_en),
    .new_pixel (blend_pixel)
  );

  assign res_nxt = '{new_pixel: blend_pixel, write_enable: write_en};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && s1_ready) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/cpab_checker.sv
// Port-level checks for the clipped pixel alpha blend block, bound to the top.
`default_nettype none

module cpab_checker import cpab_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_t                  out_data
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An empty output stage never blocks input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // With the receiver ready while a beat sits in the input register, the beat reaches the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("beat lost or late");

endmodule

bind clipped_pixel_alpha_blend cpab_checker u_checker (.*);

`default_nettype wire
